// ===== hdl/csv_to_integer_matrix_parser_macros.svh =====
// Assertion macros shared by the parser's checker.
`ifndef CSV_TO_INTEGER_MATRIX_PARSER_MACROS_SVH
`define CSV_TO_INTEGER_MATRIX_PARSER_MACROS_SVH

// Check on every rising clock edge outside reset.
`define CSVP_ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("csvp: check failed");

// Check on every rising clock edge, reset included.
`define CSVP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("csvp: check failed");

`endif

// ===== hdl/csvp_pkg.sv =====
// Types and constants shared by the CSV integer field parser.
package csvp_pkg;

   localparam logic [6:0] MAX_COLS       = 7'd64;
   localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
   localparam logic [7:0] DELIMITER_INIT = 8'd44;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [3:0] NARROW_BYTES   = 4'd4;
   localparam logic [3:0] WIDE_BYTES     = 4'd8;

   typedef enum logic [1:0] {
      CSR_COLUMN_COUNT,
      CSR_ROW_LIMIT,
      CSR_DELIMITER,
      CSR_WIDE_MASK
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic               write_valid;
      logic [28:0]        byte_offset;
      logic signed [63:0] field_value;
      logic               is_wide;
      logic               finished;
      logic [19:0]        rows_read;
   } rsp_type;

   typedef struct packed {
      logic       busy;
      logic       load;
      logic [9:0] col_off;
      logic [9:0] row_bytes;
   } offset_info_type;

endpackage

// ===== hdl/csvp_offset_calc.sv =====
// Recomputes column and row byte offsets after a layout register changes.
module csvp_offset_calc
   import csvp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [63:0]     wide_mask,
   input  logic [6:0]      cols,
   input  logic [6:0]      col_idx,
   output offset_info_type info
);

   logic            pending_ff;
   logic            s1_valid_ff;
   logic [7:0][3:0] col_cnt_ff;
   logic [7:0][3:0] row_cnt_ff;
   logic [7:0][3:0] col_cnt_in;
   logic [7:0][3:0] row_cnt_in;
   logic [63:0]     col_bits;
   logic [63:0]     row_bits;
   logic [6:0]      col_sum;
   logic [6:0]      row_sum;
   logic [7:0]      col_total;
   logic [7:0]      row_total;

   function automatic logic [63:0] below(input logic [6:0] n);
      logic [63:0] m;
      if (n[6]) begin
         m = '1;
      end else begin
         m = (64'd1 << n[5:0]) - 64'd1;
      end
      return m;
   endfunction

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + 4'(v[i]);
      end
      return c;
   endfunction

   always_comb begin
      col_bits = wide_mask & below(col_idx);
      row_bits = wide_mask & below(cols);
      for (int k = 0; k < 8; k++) begin
         col_cnt_in[k] = popcount8(col_bits[k*8 +: 8]);
         row_cnt_in[k] = popcount8(row_bits[k*8 +: 8]);
      end
   end

   always_comb begin
      col_sum = '0;
      row_sum = '0;
      for (int k = 0; k < 8; k++) begin
         col_sum = col_sum + 7'(col_cnt_ff[k]);
         row_sum = row_sum + 7'(row_cnt_ff[k]);
      end
      col_total      = 8'(col_idx) + 8'(col_sum);
      row_total      = 8'(cols) + 8'(row_sum);
      info.busy      = start || pending_ff || s1_valid_ff;
      info.load      = s1_valid_ff;
      info.col_off   = {col_total, 2'b00};
      info.row_bytes = {row_total, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         pending_ff  <= start;
         s1_valid_ff <= pending_ff;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
      end
   end

endmodule

// ===== hdl/csv_to_integer_matrix_parser.sv =====
// Top level of the CSV integer field parser.
//
// Input channel (req_): one item per text byte, or an end item with
// end_of_input set. Each item is handled in the cycle it is accepted, so a
// new item can be taken every cycle while req_stall is low. A field result
// is registered on the rsp_ channel, or in the skid register while a result
// waits, from the byte that closes the field; an end item always yields one
// result carrying finished and the row count. Results go through an output
// register backed by a one-entry skid register; req_stall rises while the
// skid register is full, so items that close no field keep flowing while a
// result waits. A write to column_count or wide_mask starts a two-stage
// popcount of the wide mask; req_stall is held from the write cycle on
// while the column and row offsets are rebuilt.
// Reset is synchronous: registers return to their defaults, no result is
// pending and parsing restarts at row zero. After the row limit or an end
// item, data bytes are dropped until the next reset.
// The csr_ port is APB-style with pready tied high; registers sit at
// byte addresses 0, 8, 16 and 24.
module csv_to_integer_matrix_parser
   import csvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   logic [6:0]      column_count_ff, column_count_in;
   logic [19:0]     row_limit_ff, row_limit_in;
   logic [7:0]      delimiter_ff, delimiter_in;
   logic [63:0]     wide_mask_ff, wide_mask_in;
   logic [6:0]      col_idx_ff, col_idx_in;
   logic [19:0]     row_idx_ff, row_idx_in;
   logic [28:0]     row_base_ff, row_base_in;
   logic [9:0]      col_off_ff, col_off_in;
   logic [9:0]      row_bytes_ff, row_bytes_in;
   logic            in_field_ff, in_field_in;
   logic            line_nonempty_ff, line_nonempty_in;
   phase_type       phase_ff, phase_in;
   logic            neg_ff, neg_in;
   logic [63:0]     acc_ff, acc_in;
   logic            done_ff, done_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_type         skid_data_ff, skid_data_in;

   logic            csr_wr;
   csr_index_type   csr_idx;
   logic            layout_wr;
   logic [6:0]      cols;
   logic [19:0]     limit;
   offset_info_type offset_info;
   logic            accept;
   logic            out_take;
   rsp_type         result;
   logic            result_valid;

   assign csr_wr    = psel && penable && pwrite;
   assign csr_idx   = csr_index_type'(paddr[4:3]);
   assign layout_wr = csr_wr && (csr_idx == CSR_COLUMN_COUNT || csr_idx == CSR_WIDE_MASK);
   assign pready    = 1'b1;

   always_comb begin
      unique case (csr_idx)
         CSR_COLUMN_COUNT: prdata = 64'(column_count_ff);
         CSR_ROW_LIMIT:    prdata = 64'(row_limit_ff);
         CSR_DELIMITER:    prdata = 64'(delimiter_ff);
         CSR_WIDE_MASK:    prdata = wide_mask_ff;
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (column_count_ff == 7'd0) begin
         cols = 7'd1;
      end else if (column_count_ff > MAX_COLS) begin
         cols = MAX_COLS;
      end else begin
         cols = column_count_ff;
      end
      limit = (row_limit_ff == 20'd0) ? 20'd1 : row_limit_ff;
   end

   csvp_offset_calc u_offset_calc (
      .clock     (clock),
      .reset     (reset),
      .start     (layout_wr),
      .wide_mask (wide_mask_ff),
      .cols      (cols),
      .col_idx   (col_idx_ff),
      .info      (offset_info)
   );

   assign req_stall = skid_valid_ff || offset_info.busy;
   assign accept    = req_valid && !req_stall;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      column_count_in = column_count_ff;
      row_limit_in    = row_limit_ff;
      delimiter_in    = delimiter_ff;
      wide_mask_in    = wide_mask_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_COLUMN_COUNT: column_count_in = pwdata[6:0];
            CSR_ROW_LIMIT:    row_limit_in    = pwdata[19:0];
            CSR_DELIMITER:    delimiter_in    = pwdata[7:0];
            CSR_WIDE_MASK:    wide_mask_in    = pwdata;
            default:          wide_mask_in    = wide_mask_ff;
         endcase
      end
   end

   always_comb begin
      logic        close_f;
      logic        close_l;
      logic        emit;
      logic        wide;
      logic [63:0] mag;
      logic [7:0]  b;
      logic        is_digit;
      logic        is_space;
      logic [63:0] dval;
      phase_type   ph_cur;
      logic [63:0] acc_cur;

      col_idx_in       = col_idx_ff;
      row_idx_in       = row_idx_ff;
      row_base_in      = row_base_ff;
      col_off_in       = col_off_ff;
      row_bytes_in     = row_bytes_ff;
      in_field_in      = in_field_ff;
      line_nonempty_in = line_nonempty_ff;
      phase_in         = phase_ff;
      neg_in           = neg_ff;
      acc_in           = acc_ff;
      done_in          = done_ff;
      result           = '0;
      result_valid     = 1'b0;
      close_f          = 1'b0;
      close_l          = 1'b0;

      b        = req_data.data_byte;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      is_space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
      dval     = 64'(b - CHAR_ZERO);
      ph_cur   = in_field_ff ? phase_ff : PH_SKIP;
      acc_cur  = in_field_ff ? acc_ff : 64'd0;
      emit     = in_field_ff && (col_idx_ff < cols);
      wide     = wide_mask_ff[col_idx_ff[5:0]];
      mag      = neg_ff ? (64'd0 - acc_ff) : acc_ff;

      if (offset_info.load) begin
         col_off_in   = offset_info.col_off;
         row_bytes_in = offset_info.row_bytes;
      end else if (accept) begin
         if (req_data.end_of_input) begin
            result_valid    = 1'b1;
            result.finished = 1'b1;
            if (!done_ff) begin
               close_f = 1'b1;
               close_l = 1'b1;
            end
         end else if (!done_ff) begin
            if (b == NEWLINE_BYTE) begin
               close_f = 1'b1;
               close_l = 1'b1;
            end else begin
               line_nonempty_in = 1'b1;
               if (b == delimiter_ff) begin
                  close_f = 1'b1;
               end else if (col_idx_ff < cols) begin
                  in_field_in = 1'b1;
                  neg_in      = in_field_ff ? neg_ff : 1'b0;
                  acc_in      = acc_cur;
                  phase_in    = ph_cur;
                  unique case (ph_cur)
                     PH_SKIP: begin
                        if (is_space) begin
                           phase_in = PH_SKIP;
                        end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                           neg_in   = (b == CHAR_MINUS);
                           phase_in = PH_SIGN;
                        end else if (is_digit) begin
                           acc_in   = dval;
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_SIGN, PH_DIGITS: begin
                        if (is_digit) begin
                           acc_in   = (acc_cur << 3) + (acc_cur << 1) + dval;
                           phase_in = PH_DIGITS;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                     PH_DONE: begin
                        phase_in = PH_DONE;
                     end
                     default: begin
                        phase_in = PH_DONE;
                     end
                  endcase
               end
            end
         end
      end

      if (close_f) begin
         in_field_in = 1'b0;
         if (emit) begin
            result_valid       = 1'b1;
            result.write_valid = 1'b1;
            result.byte_offset = row_base_ff + 29'(col_off_ff);
            result.is_wide     = wide;
            result.field_value = wide ? mag : {{32{mag[31]}}, mag[31:0]};
            col_idx_in         = col_idx_ff + 7'd1;
            col_off_in         = col_off_ff + 10'(wide ? WIDE_BYTES : NARROW_BYTES);
         end
      end

      if (close_l) begin
         if (line_nonempty_ff) begin
            row_idx_in  = row_idx_ff + 20'd1;
            row_base_in = row_base_ff + 29'(row_bytes_ff);
            if (row_idx_in >= limit) begin
               done_in = 1'b1;
            end
         end
         col_idx_in       = '0;
         col_off_in       = '0;
         line_nonempty_in = 1'b0;
      end

      if (accept && req_data.end_of_input) begin
         done_in          = 1'b1;
         result.rows_read = row_idx_in;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result_valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= 7'd1;
         row_limit_ff     <= 20'd1;
         delimiter_ff     <= DELIMITER_INIT;
         wide_mask_ff     <= '0;
         col_idx_ff       <= '0;
         row_idx_ff       <= '0;
         row_base_ff      <= '0;
         col_off_ff       <= '0;
         row_bytes_ff     <= 10'(NARROW_BYTES);
         in_field_ff      <= 1'b0;
         line_nonempty_ff <= 1'b0;
         phase_ff         <= PH_SKIP;
         neg_ff           <= 1'b0;
         acc_ff           <= '0;
         done_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         column_count_ff  <= column_count_in;
         row_limit_ff     <= row_limit_in;
         delimiter_ff     <= delimiter_in;
         wide_mask_ff     <= wide_mask_in;
         col_idx_ff       <= col_idx_in;
         row_idx_ff       <= row_idx_in;
         row_base_ff      <= row_base_in;
         col_off_ff       <= col_off_in;
         row_bytes_ff     <= row_bytes_in;
         in_field_ff      <= in_field_in;
         line_nonempty_ff <= line_nonempty_in;
         phase_ff         <= phase_in;
         neg_ff           <= neg_in;
         acc_ff           <= acc_in;
         done_ff          <= done_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_data_ff      <= rsp_data_in;
         skid_valid_ff    <= skid_valid_in;
         skid_data_ff     <= skid_data_in;
      end
   end

endmodule

// ===== hdl/csvp_checker.sv =====
// Port-level checks for the CSV integer field parser, bound to the top level.
`include "csv_to_integer_matrix_parser_macros.svh"

module csvp_checker
   import csvp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic idle_fields_zero;

   assign idle_fields_zero = (rsp_data.byte_offset == 29'd0) &&
                             (rsp_data.field_value == 64'sd0) && !rsp_data.is_wide;

   `CSVP_ASSERT_ALWAYS(a_no_result_after_reset, reset |=> !rsp_valid)
   `CSVP_ASSERT_CLK(a_rsp_valid_holds, rsp_valid && rsp_stall |=> rsp_valid)
   `CSVP_ASSERT_CLK(a_rsp_payload_holds, rsp_valid && rsp_stall |=> $stable(rsp_data))
   `CSVP_ASSERT_CLK(a_result_has_content, rsp_valid |-> rsp_data.write_valid || rsp_data.finished)
   `CSVP_ASSERT_CLK(a_idle_fields_zero, rsp_valid && !rsp_data.write_valid |-> idle_fields_zero)

endmodule

bind csv_to_integer_matrix_parser csvp_checker u_csvp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/tb_csv_to_integer_matrix_parser.sv =====
// Self-checking bench for the CSV integer field parser: register, directed and random text tests.
module tb_csv_to_integer_matrix_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import csvp_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 150;

   typedef enum logic [1:0] {SKIP_WS, AFTER_SIGN, IN_DIGITS, NUM_DONE} num_phase_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [4:0]  paddr     = '0;
   logic [63:0] pwdata    = '0;
   logic [63:0] prdata;
   logic        pready;

   int errors    = 0;
   int cycles    = 0;
   int stall_run = 0;
   bit calm      = 1'b0;

   logic [6:0]    cfg_cols      = 7'd1;
   logic [19:0]   cfg_rows      = 20'd1;
   logic [7:0]    cfg_delim     = DELIMITER_INIT;
   logic [63:0]   cfg_wide_mask = '0;
   int            col_idx       = 0;
   logic [19:0]   rows_done     = '0;
   logic [28:0]   row_base      = '0;
   bit            field_open    = 1'b0;
   bit            line_seen     = 1'b0;
   num_phase_type num_phase     = SKIP_WS;
   bit            minus         = 1'b0;
   logic [63:0]   acc           = '0;
   bit            parse_stopped = 1'b0;
   rsp_type       fields_due[$];

   csv_to_integer_matrix_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic int cols_used();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_COLS) return int'(MAX_COLS);
      return int'(cfg_cols);
   endfunction

   function automatic logic [28:0] prefix_bytes(input int col);
      logic [28:0] sum;
      int i;
      sum = '0;
      for (i = 0; i < col && i < 64; i++) begin
         sum += 29'(cfg_wide_mask[i] ? WIDE_BYTES : NARROW_BYTES);
      end
      return sum;
   endfunction

   function automatic bit close_field(inout rsp_type r);
      logic [63:0] v;
      bit hit;
      hit = 1'b0;
      if (field_open && col_idx < cols_used()) begin
         v = minus ? -acc : acc;
         if (!cfg_wide_mask[col_idx]) v = {{32{v[31]}}, v[31:0]};
         r.write_valid = 1'b1;
         r.byte_offset = row_base + prefix_bytes(col_idx);
         r.field_value = v;
         r.is_wide     = cfg_wide_mask[col_idx];
         col_idx++;
         hit = 1'b1;
      end
      field_open = 1'b0;
      return hit;
   endfunction

   function automatic void close_line();
      if (line_seen) begin
         rows_done = rows_done + 20'd1;
         row_base  = row_base + prefix_bytes(cols_used());
         if (rows_done >= ((cfg_rows == 0) ? 20'd1 : cfg_rows)) parse_stopped = 1'b1;
      end
      col_idx   = 0;
      line_seen = 1'b0;
   endfunction

   function automatic void parse_item(input req_type item);
      rsp_type r;
      bit hit, dig, ws;
      logic [7:0] b;
      r   = '0;
      hit = 1'b0;
      b   = item.data_byte;
      if (item.end_of_input) begin
         if (!parse_stopped) begin
            void'(close_field(r));
            close_line();
            parse_stopped = 1'b1;
         end
         r.finished  = 1'b1;
         r.rows_read = rows_done;
         hit = 1'b1;
      end else if (!parse_stopped) begin
         if (b == NEWLINE_BYTE) begin
            hit = close_field(r);
            close_line();
         end else begin
            line_seen = 1'b1;
            if (b == cfg_delim) begin
               hit = close_field(r);
            end else if (col_idx < cols_used()) begin
               if (!field_open) begin
                  field_open = 1'b1;
                  num_phase  = SKIP_WS;
                  minus      = 1'b0;
                  acc        = '0;
               end
               dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
               ws  = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
               case (num_phase)
                  SKIP_WS: begin
                     if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                        minus     = (b == CHAR_MINUS);
                        num_phase = AFTER_SIGN;
                     end else if (dig) begin
                        acc       = 64'(b - CHAR_ZERO);
                        num_phase = IN_DIGITS;
                     end else if (!ws) begin
                        num_phase = NUM_DONE;
                     end
                  end
                  AFTER_SIGN, IN_DIGITS: begin
                     if (dig) begin
                        acc       = acc * 64'd10 + 64'(b - CHAR_ZERO);
                        num_phase = IN_DIGITS;
                     end else begin
                        num_phase = NUM_DONE;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
      if (hit) fields_due.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fields_due.size() == 0) begin
            $display("%0t ns: result %p arrived with none expected", $time, rsp_data);
            errors++;
         end else begin
            want = fields_due.pop_front();
            check_field("write_valid", 64'(want.write_valid), 64'(rsp_data.write_valid));
            check_field("byte_offset", 64'(want.byte_offset), 64'(rsp_data.byte_offset));
            check_field("field_value", want.field_value, rsp_data.field_value);
            check_field("is_wide", 64'(want.is_wide), 64'(rsp_data.is_wide));
            check_field("finished", 64'(want.finished), 64'(rsp_data.finished));
            check_field("rows_read", 64'(want.rows_read), 64'(rsp_data.rows_read));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_run > 0) stall_run--;
      else if (!calm && $urandom_range(0, 2) == 0) stall_run = pick_gap();
      rsp_stall <= (stall_run > 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(input req_type item);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      parse_item(item);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type item;
      item.data_byte    = b;
      item.end_of_input = 1'b0;
      send_item(item);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Wait for the parser to drain, then write and read back one register.
   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      logic [63:0] stored;
      req_valid <= 1'b0;
      while (fields_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_COLUMN_COUNT: begin
            cfg_cols = value[6:0];
            stored   = 64'(cfg_cols);
         end
         CSR_ROW_LIMIT: begin
            cfg_rows = value[19:0];
            stored   = 64'(cfg_rows);
         end
         CSR_DELIMITER: begin
            cfg_delim = value[7:0];
            stored    = 64'(cfg_delim);
         end
         CSR_WIDE_MASK: begin
            cfg_wide_mask = value;
            stored        = value;
         end
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored) begin
         $display("%0t ns: %s read back expected %h, got %h", $time, idx.name(), stored, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic build_line(ref logic [7:0] txt[$]);
      int nf, nd, f, k;
      txt.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom));
      end else begin
         if ($urandom_range(0, 7) == 0) nf = cols_used() + $urandom_range(0, 2);
         else nf = $urandom_range(0, 5);
         for (f = 0; f < nf; f++) begin
            if (f > 0) txt.push_back(cfg_delim);
            if ($urandom_range(0, 7) == 0) continue;
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 2)) begin
                  k = $urandom_range(0, 4);
                  txt.push_back((k == 0) ? CHAR_SPACE : CHAR_TAB + 8'(k == 1 ? 0 : k));
               end
            end
            k = $urandom_range(0, 3);
            if (k == 0) txt.push_back(CHAR_PLUS);
            else if (k == 1) txt.push_back(CHAR_MINUS);
            k = $urandom_range(0, 19);
            if (k == 0) nd = 0;
            else if (k < 3) nd = $urandom_range(19, 22);
            else if (k < 6) nd = $urandom_range(8, 11);
            else nd = $urandom_range(1, 4);
            repeat (nd) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0) txt.push_back(8'($urandom));
         end
      end
      if ($urandom_range(0, 11) == 0) txt.push_back(NEWLINE_BYTE);
      txt.push_back(NEWLINE_BYTE);
   endtask

   task automatic test_registers();
      csr_write(CSR_COLUMN_COUNT, 64'd127);
      csr_write(CSR_COLUMN_COUNT, 64'd0);
      csr_write(CSR_ROW_LIMIT, 64'd1);
      csr_write(CSR_ROW_LIMIT, {$urandom, $urandom});
      csr_write(CSR_ROW_LIMIT, 64'hFFFFF);
      csr_write(CSR_DELIMITER, 64'hFF);
      csr_write(CSR_DELIMITER, 64'h0);
      csr_write(CSR_WIDE_MASK, '1);
      csr_write(CSR_WIDE_MASK, '0);
   endtask

   task automatic test_field_syntax();
      csr_write(CSR_COLUMN_COUNT, 64'd3);
      csr_write(CSR_WIDE_MASK, 64'h2);
      csr_write(CSR_DELIMITER, 64'(DELIMITER_INIT));
      send_text(" -3,+,");
      send_byte(8'hFF);
      send_text("9\n,,\n\n2147483648,");
      send_byte(8'h00);
      send_text("7,1,5\n");
   endtask

   task automatic test_random_text();
      logic [7:0]  txt[$];
      logic [7:0]  dl;
      logic [63:0] wm;
      int nc, ph, sent;
      for (ph = 0; ph < 9; ph++) begin
         wm = {$urandom, $urandom};
         nc = $urandom_range(1, 8);
         dl = ($urandom_range(0, 1) == 0) ? DELIMITER_INIT : 8'($urandom);
         case (ph)
            0: begin nc = 3; dl = DELIMITER_INIT; end
            1: begin nc = 64; wm = '1; dl = ";"; end
            2: begin nc = 1; wm = '0; dl = 8'h00; end
            3: begin nc = 4; dl = NEWLINE_BYTE; end
            4: begin nc = 0; dl = CHAR_TAB; end
            5: begin nc = 127; dl = DELIMITER_INIT; end
            default: ;
         endcase
         calm = (ph % 3 == 2);
         csr_write(CSR_COLUMN_COUNT, 64'(nc));
         csr_write(CSR_ROW_LIMIT, (ph == 0) ? 64'hFFFFF : 64'($urandom_range(5000, 1048575)));
         csr_write(CSR_DELIMITER, 64'(dl));
         csr_write(CSR_WIDE_MASK, wm);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_line(txt);
            foreach (txt[i]) begin
               if (sent < PHASE_ITEMS) begin
                  send_byte(txt[i]);
                  sent++;
               end
            end
         end
      end
   endtask

   // Stop either on the row limit or on an end item with a field pending.
   task automatic test_end_of_parse();
      logic [7:0] txt[$];
      req_type item;
      calm = 1'b0;
      csr_write(CSR_COLUMN_COUNT, 64'd2);
      csr_write(CSR_ROW_LIMIT, 64'd1);
      if ($urandom_range(0, 1) == 0) begin
         build_line(txt);
         foreach (txt[i]) send_byte(txt[i]);
         send_text("1,2\n");
      end else begin
         send_text("-12,4");
         item.data_byte    = 8'($urandom);
         item.end_of_input = 1'b1;
         send_item(item);
      end
      repeat (20) send_byte(8'($urandom));
      repeat (3) begin
         item.data_byte    = 8'($urandom);
         item.end_of_input = 1'b1;
         send_item(item);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_registers();
      test_field_syntax();
      test_random_text();
      test_end_of_parse();
      req_valid <= 1'b0;
      while (fields_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
